@@ rtl/bmvst_pkg.sv @@
// ----------------------------------------------------------------------------
// bmvst_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
`default_nettype none

package bmvst_pkg;

    // fixed field widths
    localparam int X_W       = 24;   // vector element, signed q7.16
    localparam int SUM_W     = 48;   // accumulator, signed q31.16
    localparam int CMD_W     = 2;
    localparam int GB_W      = 4;    // group_bits register
    localparam int NC_W      = 11;   // num_columns register
    localparam int CFG_W     = 11;   // widest register
    localparam int REG_IDX_W = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_GROUP_BITS  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_COLUMNS = 2'd1;

    // reset values of the registers
    localparam logic [GB_W-1:0] GROUP_BITS_RST  = 4'd4;
    localparam logic [NC_W-1:0] NUM_COLUMNS_RST = 11'd1024;

    typedef struct packed {
        logic capture_load;  // latch element from the input
        logic capture_code;  // latch code, zero element
        logic code_rd_in;    // table/accumulator reads from the input code
        logic code_rd_reg;   // same reads from the latched code
        logic code_wr;       // saturating accumulate and pointer advance
        logic read_clr;      // read and clear the read pointer's accumulator
        logic out_load;      // move read data into the output register
        logic sweep_rd;      // read one table entry of the doubling sweep
        logic sweep_end;     // close the sweep, count the element
        logic clr_step;      // one entry of the post-reset clearing pass
    } ctrl_cmd_t;

    typedef struct packed {
        logic group_full;
        logic k_last;
        logic clr_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

@@ rtl/binary_matrix_vector_subset_table_core.sv @@
// ----------------------------------------------------------------------------
// binary_matrix_vector_subset_table_core
// a-transpose times x for a 0/1 matrix, subset-sum table per row group
// ----------------------------------------------------------------------------
// one item is in flight at a time. a column code (tuser 1) with its group
// full reads the subset table and the column's accumulator, then writes a
// saturating add back to the accumulator memory. a read-and-clear (tuser 2)
// reads and zeroes the column's accumulator, then waits while a result is
// still pending in the output register. a load (tuser 0) at group position
// pos doubles the table through its one read port and one write port, one
// entry per cycle; a load with the group full leaves the table unchanged. a
// column code that finds the group short first pads it with zero elements,
// each doubling the table like a load. after reset a clearing pass zeroes the
// accumulator memory, during which s_tready stays low; configuration writes
// are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_matrix_vector_subset_table_core #(
    parameter int MAX_GROUP_BITS = 8,
    parameter int MAX_COLUMNS    = 1024
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    // configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [bmvst_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [bmvst_pkg::CFG_W-1:0]     cfg_data,

    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // x_value [23:0], code [24 +: MAX_GROUP_BITS], zero fill
    input  wire logic [((bmvst_pkg::X_W + MAX_GROUP_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // cmd [1:0]
    input  wire logic [bmvst_pkg::CMD_W-1:0]     s_tuser,

    // results
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // sum [47:0], column [48 +: clog2(MAX_COLUMNS)], zero fill
    output logic [((bmvst_pkg::SUM_W + $clog2(MAX_COLUMNS) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                 m_tlast
);
    import bmvst_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int OUT_W = ((SUM_W + CW + 7) / 8) * 8;

    ctrl_cmd_t        cmd;
    ctrl_stat_t       stat;
    logic [SUM_W-1:0] sum;
    logic [CW-1:0]    column;

    // sequencer: dispatch, sweeps, padding, clearing pass
    bmvst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // memories, pointers and output register
    bmvst_dp #(
        .MAX_GROUP_BITS (MAX_GROUP_BITS),
        .MAX_COLUMNS    (MAX_COLUMNS),
        .CW             (CW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_x_value (s_tdata[X_W-1:0]),
        .s_code    (s_tdata[X_W +: MAX_GROUP_BITS]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_sum     (sum),
        .m_column  (column),
        .m_last    (m_tlast)
    );

    // pack the result transaction, sum in the low bits
    assign m_tdata = OUT_W'({column, sum});

endmodule

`default_nettype wire

@@ rtl/bmvst_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmvst_ctrl
// sequencer: item dispatch, table doubling sweeps, padding, clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module bmvst_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    input  wire logic [bmvst_pkg::CMD_W-1:0] s_tuser,
    output logic                             s_tready,
    input  wire bmvst_pkg::ctrl_stat_t       stat,
    output bmvst_pkg::ctrl_cmd_t             cmd
);
    import bmvst_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_PAD_CHECK,
        ST_CODE_WR,
        ST_READ_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd_next = s_tuser;
                    case (s_tuser)
                        CMD_LOAD: begin
                            cmd.capture_load = 1'b1;
                            if (!stat.group_full) begin
                                state_next = ST_SWEEP;
                            end
                        end
                        CMD_CODE: begin
                            cmd.capture_code = 1'b1;
                            if (stat.group_full) begin
                                cmd.code_rd_in = 1'b1;
                                state_next     = ST_CODE_WR;
                            end else begin
                                state_next = ST_SWEEP;
                            end
                        end
                        CMD_READ: begin
                            cmd.read_clr = 1'b1;
                            state_next   = ST_READ_OUT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                cmd.sweep_rd = 1'b1;
                if (stat.k_last) begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END: begin
                cmd.sweep_end = 1'b1;
                state_next    = (cmd_reg == CMD_LOAD) ? ST_IDLE : ST_PAD_CHECK;
            end
            ST_PAD_CHECK: begin
                if (stat.group_full) begin
                    cmd.code_rd_reg = 1'b1;
                    state_next      = ST_CODE_WR;
                end else begin
                    state_next = ST_SWEEP;
                end
            end
            ST_CODE_WR: begin
                cmd.code_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_READ_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cmd_reg   <= CMD_LOAD;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bmvst_dp.sv @@
// ----------------------------------------------------------------------------
// bmvst_dp
// datapath: subset table, accumulator memory, pointers, output register
// ----------------------------------------------------------------------------
`default_nettype none

module bmvst_dp #(
    parameter int MAX_GROUP_BITS = 8,
    parameter int MAX_COLUMNS    = 1024,
    parameter int CW             = $clog2(MAX_COLUMNS)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bmvst_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [bmvst_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [bmvst_pkg::X_W-1:0]       s_x_value,
    input  wire logic [MAX_GROUP_BITS-1:0]       s_code,
    input  wire bmvst_pkg::ctrl_cmd_t            cmd,
    output bmvst_pkg::ctrl_stat_t                stat,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [bmvst_pkg::SUM_W-1:0]          m_sum,
    output logic [CW-1:0]                        m_column,
    output logic                                 m_last
);
    import bmvst_pkg::*;

    localparam int AW        = MAX_GROUP_BITS;
    localparam int TBL_DEPTH = 1 << AW;
    localparam int TW        = X_W + $clog2(MAX_GROUP_BITS);
    localparam int LCW       = $clog2(MAX_GROUP_BITS + 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration
    logic [GB_W-1:0] group_bits_reg;
    logic [NC_W-1:0] num_columns_reg;
    logic [LCW-1:0]  g_eff;
    logic [CW:0]     n_eff;

    // group and pointer state
    logic [LCW-1:0] lc_reg;
    logic [CW-1:0]  code_col_reg;
    logic [CW-1:0]  read_col_reg;
    logic [CW-1:0]  clr_cnt_reg;
    logic [AW-1:0]  k_reg;
    logic [AW-1:0]  wr_k_reg;
    logic           wr_pend_reg;
    logic signed [TW-1:0] x_reg;
    logic [AW-1:0]  code_reg;
    logic [CW-1:0]  col_q_reg;
    logic [CW-1:0]  rd_col_q_reg;

    // memories
    logic [TW-1:0]    tbl_mem [TBL_DEPTH];
    logic [SUM_W-1:0] acc_mem [MAX_COLUMNS];
    logic [TW-1:0]    tbl_rd_reg;
    logic             tbl_zero_reg;
    logic [SUM_W-1:0] acc_rd_reg;

    // output register
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic [CW-1:0]    out_col_reg;
    logic             out_last_reg;

    logic [31:0]   gb_wide;
    logic [31:0]   nc_wide;
    logic [AW-1:0] half;
    logic [AW:0]   mask_w;
    logic [AW-1:0] idx_in;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] code_col_eff;
    logic [CW-1:0] read_col_eff;
    logic          code_wrap;
    logic          read_last;

    logic [AW-1:0] tbl_raddr;
    logic          tbl_re;
    logic signed [TW-1:0] tbl_val;
    logic signed [TW-1:0] tbl_wdata;

    logic signed [SUM_W:0]   add_full;
    logic signed [SUM_W-1:0] acc_sat;
    logic                    acc_we;
    logic [CW-1:0]           acc_waddr;
    logic [SUM_W-1:0]        acc_wdata;
    logic                    acc_re;
    logic [CW-1:0]           acc_raddr;

    // effective register values: zero acts as one, clamp to the maxima
    always_comb begin
        gb_wide = {{(32-GB_W){1'b0}}, group_bits_reg};
        if (gb_wide == 32'd0) begin
            gb_wide = 32'd1;
        end else if (gb_wide > 32'(MAX_GROUP_BITS)) begin
            gb_wide = 32'(MAX_GROUP_BITS);
        end
        g_eff = gb_wide[LCW-1:0];

        nc_wide = {{(32-NC_W){1'b0}}, num_columns_reg};
        if (nc_wide == 32'd0) begin
            nc_wide = 32'd1;
        end else if (nc_wide > 32'(MAX_COLUMNS)) begin
            nc_wide = 32'(MAX_COLUMNS);
        end
        n_eff = nc_wide[CW:0];
    end

    assign half    = AW'(1) << lc_reg;
    assign mask_w  = ((AW+1)'(1) << g_eff) - (AW+1)'(1);
    assign idx_in  = s_code & mask_w[AW-1:0];
    assign idx_reg = code_reg & mask_w[AW-1:0];

    assign code_col_eff = ({1'b0, code_col_reg} >= n_eff) ? '0 : code_col_reg;
    assign read_col_eff = ({1'b0, read_col_reg} >= n_eff) ? '0 : read_col_reg;
    assign code_wrap    = (({1'b0, col_q_reg} + (CW+1)'(1)) >= n_eff);
    assign read_last    = ({1'b0, rd_col_q_reg} == (n_eff - (CW+1)'(1)));

    assign stat.group_full = (lc_reg >= g_eff);
    assign stat.k_last     = (k_reg == (half - AW'(1)));
    assign stat.clr_last   = (clr_cnt_reg == CW'(MAX_COLUMNS - 1));
    assign stat.out_free   = !out_valid_reg || m_tready;

    // table read port: sweep entry or column code
    always_comb begin
        tbl_re    = cmd.sweep_rd || cmd.code_rd_in || cmd.code_rd_reg;
        tbl_raddr = k_reg;
        if (cmd.code_rd_in) begin
            tbl_raddr = idx_in;
        end else if (cmd.code_rd_reg) begin
            tbl_raddr = idx_reg;
        end
    end

    // entry zero is the empty subset
    assign tbl_val   = tbl_zero_reg ? '0 : $signed(tbl_rd_reg);
    assign tbl_wdata = tbl_val + x_reg;

    // saturating accumulate
    assign add_full = $signed({acc_rd_reg[SUM_W-1], acc_rd_reg})
                    + $signed({{(SUM_W+1-TW){tbl_val[TW-1]}}, tbl_val});
    always_comb begin
        if (add_full[SUM_W] != add_full[SUM_W-1]) begin
            acc_sat = add_full[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            acc_sat = add_full[SUM_W-1:0];
        end
    end

    // accumulator ports
    always_comb begin
        acc_re    = cmd.code_rd_in || cmd.code_rd_reg || cmd.read_clr;
        acc_raddr = cmd.read_clr ? read_col_eff : code_col_eff;
        acc_we    = cmd.clr_step || cmd.read_clr || cmd.code_wr;
        acc_waddr = clr_cnt_reg;
        acc_wdata = '0;
        if (cmd.read_clr) begin
            acc_waddr = read_col_eff;
        end else if (cmd.code_wr) begin
            acc_waddr = col_q_reg;
            acc_wdata = acc_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_re) begin
            tbl_rd_reg   <= tbl_mem[tbl_raddr];
            tbl_zero_reg <= (tbl_raddr == '0);
        end
        if (wr_pend_reg) begin
            tbl_mem[wr_k_reg | half] <= tbl_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_re) begin
            acc_rd_reg <= acc_mem[acc_raddr];
        end
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
    end

    // payload latches
    always_ff @(posedge aclk) begin
        if (cmd.capture_load) begin
            x_reg <= TW'($signed(s_x_value));
        end else if (cmd.capture_code) begin
            x_reg    <= '0;
            code_reg <= s_code;
        end
        if (cmd.sweep_rd) begin
            wr_k_reg <= k_reg;
        end
        if (cmd.code_rd_in || cmd.code_rd_reg) begin
            col_q_reg <= code_col_eff;
        end
        if (cmd.read_clr) begin
            rd_col_q_reg <= read_col_eff;
        end
        if (cmd.out_load) begin
            out_sum_reg  <= acc_rd_reg;
            out_col_reg  <= rd_col_q_reg;
            out_last_reg <= read_last;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_bits_reg  <= GROUP_BITS_RST;
            num_columns_reg <= NUM_COLUMNS_RST;
            lc_reg          <= '0;
            code_col_reg    <= '0;
            read_col_reg    <= '0;
            clr_cnt_reg     <= '0;
            k_reg           <= '0;
            wr_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_GROUP_BITS:  group_bits_reg  <= cfg_data[GB_W-1:0];
                    REG_NUM_COLUMNS: num_columns_reg <= cfg_data[NC_W-1:0];
                    default: ;
                endcase
            end
            wr_pend_reg <= cmd.sweep_rd;
            if (cmd.capture_load || cmd.capture_code || cmd.sweep_end) begin
                k_reg <= '0;
            end else if (cmd.sweep_rd) begin
                k_reg <= k_reg + AW'(1);
            end
            if (cmd.sweep_end) begin
                lc_reg <= lc_reg + LCW'(1);
            end else if (cmd.code_wr && code_wrap) begin
                lc_reg <= '0;
            end
            if (cmd.code_wr) begin
                code_col_reg <= code_wrap ? '0 : col_q_reg + CW'(1);
            end
            if (cmd.out_load) begin
                read_col_reg <= read_last ? '0 : rd_col_q_reg + CW'(1);
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_sum    = out_sum_reg;
    assign m_column = out_col_reg;
    assign m_last   = out_last_reg;

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while occupied");

    a_acc_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clr_step, cmd.read_clr, cmd.code_wr}))
        else $error("two accumulator write sources at once");

    a_wrap_new_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.code_wr && code_wrap) |=> (lc_reg == '0 && code_col_reg == '0))
        else $error("column wrap did not start a new group");

    a_sweep_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_rd |-> (k_reg < half && !stat.group_full))
        else $error("table sweep outside the current half");

endmodule

`default_nettype wire

@@ tb/sv/bmvst_result_checker.sv @@
// ----------------------------------------------------------------------------
// bmvst_result_checker
// watches the item, result and register ports, predicts each read-out and
// compares every result transaction field by field
// ----------------------------------------------------------------------------
module bmvst_result_checker #(
    parameter int MAX_GROUP_BITS = 8,
    parameter int MAX_COLUMNS    = 1024,
    parameter int S_DATA_W       = 32,
    parameter int M_DATA_W       = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bmvst_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [bmvst_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [S_DATA_W-1:0]             s_tdata,
    input  wire logic [bmvst_pkg::CMD_W-1:0]     s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [M_DATA_W-1:0]             m_tdata,
    input  wire logic                            m_tlast,
    output int                                   mismatch_count,
    output int                                   pending_reads
);

    import bmvst_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int TBL_W = X_W + $clog2(MAX_GROUP_BITS) + 1;
    localparam logic signed [SUM_W:0] SUM_HI = {2'b00, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W:0] SUM_LO = {2'b11, {(SUM_W-1){1'b0}}};

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic [COL_W-1:0]        column;
        logic                    last;
    } column_readout_t;

    column_readout_t expected_readouts[$];

    logic [GB_W-1:0]         group_bits_reg;
    logic [NC_W-1:0]         num_columns_reg;
    logic signed [TBL_W-1:0] subset_sums [1 << MAX_GROUP_BITS];
    logic signed [SUM_W-1:0] column_sums [MAX_COLUMNS];
    int unsigned             rows_loaded;
    int unsigned             code_col;
    int unsigned             read_col;

    function automatic int unsigned rows_per_group();
        if (group_bits_reg == 0) return 1;
        if (group_bits_reg > MAX_GROUP_BITS) return MAX_GROUP_BITS;
        return group_bits_reg;
    endfunction

    function automatic int unsigned column_count();
        if (num_columns_reg == 0) return 1;
        if (num_columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return num_columns_reg;
    endfunction

    function automatic logic signed [SUM_W-1:0] clamp_add(logic signed [SUM_W-1:0] a,
                                                          logic signed [TBL_W-1:0] b);
        logic signed [SUM_W:0] s;
        s = a + b;
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        return s[SUM_W-1:0];
    endfunction

    // new row element: upper half of the table is the lower half plus x
    task automatic extend_subset_sums(input logic signed [X_W-1:0] x);
        int unsigned half;
        if (rows_loaded == 0) subset_sums[0] = '0;
        half = 1 << rows_loaded;
        for (int unsigned k = 0; k < half; k++) begin
            subset_sums[k + half] = subset_sums[k] + x;
        end
        rows_loaded++;
    endtask

    task automatic predict_item(input logic [CMD_W-1:0] cmd, input logic signed [X_W-1:0] x,
                                input logic [7:0] code);
        int unsigned     g;
        int unsigned     n;
        int unsigned     idx;
        column_readout_t want;
        g = rows_per_group();
        n = column_count();
        case (cmd)
            CMD_LOAD: begin
                if (rows_loaded < g) extend_subset_sums(x);
            end
            CMD_CODE: begin
                while (rows_loaded < g) extend_subset_sums('0);
                if (code_col >= n) code_col = 0;
                idx = int'(code) & ((1 << g) - 1);
                column_sums[code_col] = clamp_add(column_sums[code_col], subset_sums[idx]);
                code_col++;
                if (code_col >= n) begin
                    code_col = 0;
                    rows_loaded = 0;
                end
            end
            CMD_READ: begin
                if (read_col >= n) read_col = 0;
                want.sum    = column_sums[read_col];
                want.column = read_col[COL_W-1:0];
                want.last   = (read_col == n - 1);
                column_sums[read_col] = '0;
                read_col = (read_col + 1 >= n) ? 0 : read_col + 1;
                expected_readouts.insert(expected_readouts.size(), want);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : watch
        column_readout_t want;
        if (!aresetn) begin
            group_bits_reg  = GROUP_BITS_RST;
            num_columns_reg = NUM_COLUMNS_RST;
            foreach (subset_sums[i]) subset_sums[i] = '0;
            foreach (column_sums[i]) column_sums[i] = '0;
            rows_loaded    = 0;
            code_col       = 0;
            read_col       = 0;
            mismatch_count = 0;
            expected_readouts.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GROUP_BITS:  group_bits_reg  = cfg_data[GB_W-1:0];
                    REG_NUM_COLUMNS: num_columns_reg = cfg_data[NC_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_readouts.size() == 0) begin
                    $error("result transaction with none expected: sum %0d column %0d last %0b",
                           $signed(m_tdata[SUM_W-1:0]), m_tdata[SUM_W +: COL_W], m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_readouts.pop_front();
                    if (m_tdata[SUM_W-1:0] !== want.sum) begin
                        $error("sum: expected %0d, actual %0d",
                               want.sum, $signed(m_tdata[SUM_W-1:0]));
                        mismatch_count++;
                    end
                    if (m_tdata[SUM_W +: COL_W] !== want.column) begin
                        $error("column: expected %0d, actual %0d",
                               want.column, m_tdata[SUM_W +: COL_W]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_item(s_tuser, $signed(s_tdata[X_W-1:0]), s_tdata[X_W +: 8]);
            end
        end
        pending_reads = expected_readouts.size();
    end

endmodule

@@ tb/sv/tb_binary_matrix_vector_subset_table_core.sv @@
// ----------------------------------------------------------------------------
// tb_binary_matrix_vector_subset_table_core
// stimulus and verdict for the subset-table matrix-vector core
// ----------------------------------------------------------------------------
// a directed opening covers field extremes, every command, short groups,
// loads into a full group, a shrunken group size and out-of-range pointers.
// random phases follow, each under its own register setting, made mostly of
// whole groups (loads, one pass of column codes, read-outs) with some noise.
// both sides idle at random; one phase stalls the result side for a long
// stretch while reads keep coming. a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_binary_matrix_vector_subset_table_core;

    import bmvst_pkg::*;

    localparam int MAX_GROUP_BITS = 8;
    localparam int MAX_COLUMNS    = 1024;
    localparam int S_DATA_W       = ((X_W + MAX_GROUP_BITS + 7) / 8) * 8;
    localparam int M_DATA_W       = ((SUM_W + $clog2(MAX_COLUMNS) + 7) / 8) * 8;

    localparam int MAX_GAP        = 17;
    localparam int SETTLE_CYCLES  = 400;    // longest no-result item is a padded group
    localparam int HOLD_CYCLES    = 300;    // long result-side stall
    localparam int WATCHDOG_LIMIT = 20000;  // covers the clearing pass and settle pauses
    localparam int TARGET_ITEMS   = 500;
    localparam int PHASE_ITEMS    = 60;

    // the fourth command value, which the core ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;  // x_value [23:0], code [31:24]
    logic [CMD_W-1:0]      s_tuser   = '0;  // cmd [1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // sum [47:0], column [57:48], zero fill
    logic                  m_tlast;

    int                    mismatch_count;
    int                    pending_reads;

    // shared stimulus controls
    bit                    no_idle  = 1'b0;  // both sides run without gaps
    bit                    hold_req = 1'b0;  // receiver takes one long stall
    int unsigned           items_sent = 0;   // non-ignored command transactions
    int unsigned           rows_eff;         // group size the core is using
    int unsigned           cols_eff;         // column count the core is using

    always #5 aclk = ~aclk;

    binary_matrix_vector_subset_table_core #(
        .MAX_GROUP_BITS (MAX_GROUP_BITS),
        .MAX_COLUMNS    (MAX_COLUMNS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    bmvst_result_checker #(
        .MAX_GROUP_BITS (MAX_GROUP_BITS),
        .MAX_COLUMNS    (MAX_COLUMNS),
        .S_DATA_W       (S_DATA_W),
        .M_DATA_W       (M_DATA_W)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_reads  (pending_reads)
    );

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // element values lean toward the q7.16 extremes, zero and minus one lsb
    function automatic logic [X_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            default: return X_W'($urandom);
        endcase
    endfunction

    // one input transaction; valid stays up when the next one follows at once
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [X_W-1:0] x,
                             input logic [7:0] code);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({code, x});
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    // drain: every read-out back, then room for a padded group still running
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reads != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both registers on back-to-back edges, enable held across them
    task automatic write_config(input int unsigned rows, input int unsigned cols);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GROUP_BITS;
        cfg_data  <= CFG_W'(rows);
        @(posedge aclk);
        cfg_index <= REG_NUM_COLUMNS;
        cfg_data  <= CFG_W'(cols);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rows_eff = (rows == 0) ? 1 : (rows > MAX_GROUP_BITS) ? MAX_GROUP_BITS : rows;
        cols_eff = (cols == 0) ? 1 : (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
    endtask

    // mostly whole groups with random content, some stray transactions
    task automatic run_phase(input int unsigned budget);
        int unsigned start;
        int unsigned n_load;
        int unsigned n_code;
        int unsigned n_read;
        start = items_sent;
        while (items_sent - start < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                // short group now and then, an extra load into a full one too
                n_load = ($urandom_range(0, 4) == 0) ? $urandom_range(0, rows_eff) : rows_eff;
                if ($urandom_range(0, 5) == 0) n_load++;
                repeat (n_load) send_item(CMD_LOAD, pick_element(), 8'($urandom));
                if (cols_eff > 24) n_code = $urandom_range(1, 24);
                else if ($urandom_range(0, 3) == 0) n_code = $urandom_range(1, cols_eff);
                else n_code = cols_eff;
                repeat (n_code) send_item(CMD_CODE, X_W'($urandom), 8'($urandom));
                n_read = $urandom_range(0, (cols_eff > 8) ? 8 : cols_eff);
                repeat (n_read) send_item(CMD_READ, X_W'($urandom), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(CMD_W'($urandom_range(0, 3)), pick_element(), 8'($urandom));
                end
            end
        end
    endtask

    // reset held low once at the start, then released
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // result side: random stalls, one long hold when asked
    initial begin : receiver
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = draw_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // watchdog: too long without any transaction on either channel
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("binary_matrix_vector_subset_table_core verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned rows;
        int unsigned cols;
        @(posedge aclk iff aresetn);

        // directed, widest group over two columns; written during the clearing pass
        write_config(8, 2);
        send_item(CMD_LOAD, 24'h7FFFFF, 8'h00);   // largest element
        send_item(CMD_LOAD, 24'h800000, 8'h00);   // most negative element
        send_item(CMD_LOAD, 24'hFFFFFF, 8'h00);   // minus one lsb
        send_item(CMD_CODE, 24'h000000, 8'hFF);   // short group gets padded, all rows
        send_item(CMD_LOAD, 24'h001234, 8'h00);   // group full: ignored
        send_item(CMD_CODE, 24'hFFFFFF, 8'h00);   // empty code, pointer wraps
        send_item(CMD_UNUSED, 24'h5A5A5A, 8'hA5); // unused command: no result
        send_item(CMD_READ, 24'h000000, 8'h00);
        send_item(CMD_READ, 24'h000000, 8'h00);   // last column flagged
        send_item(CMD_READ, 24'h000000, 8'h00);   // cleared column reads zero
        // fill a whole group and leave it unused
        send_item(CMD_LOAD, 24'h7FFFFF, 8'h00);
        send_item(CMD_LOAD, 24'h800000, 8'h00);
        send_item(CMD_LOAD, 24'h555555, 8'h00);
        send_item(CMD_LOAD, 24'hAAAAAA, 8'h00);
        send_item(CMD_LOAD, 24'h000001, 8'h00);
        send_item(CMD_LOAD, 24'hFFFFFF, 8'h00);
        send_item(CMD_LOAD, 24'h123456, 8'h00);
        send_item(CMD_LOAD, 24'h000000, 8'h00);
        settle();

        // group size shrunk below what is loaded; zero columns act as one,
        // so the read pointer left at column 1 is out of range
        write_config(2, 0);
        send_item(CMD_CODE, 24'h000000, 8'hFF);   // upper code bits ignored
        send_item(CMD_CODE, 24'h000000, 8'hAA);   // fresh group, padded with zeros
        send_item(CMD_READ, 24'h000000, 8'h00);
        send_item(CMD_READ, 24'h000000, 8'h00);

        // random phases, extremes of both registers first
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            settle();
            case (phase)
                0: begin rows = 1;  cols = 1;    end
                1: begin rows = 8;  cols = 1024; end
                2: begin rows = 15; cols = 2047; end
                3: begin rows = 0;  cols = 5;    end
                default: begin
                    rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 8);
                    cols = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 1024)
                                                       : $urandom_range(1, 16);
                end
            endcase
            write_config(rows, cols);
            no_idle = (phase % 3 == 1);
            if (phase == 2) begin
                // result side stalls long while reads keep arriving back to back
                no_idle  = 1'b1;
                hold_req = 1'b1;
                repeat (12) send_item(CMD_READ, X_W'($urandom), 8'($urandom));
                no_idle  = 1'b0;
            end
            run_phase(PHASE_ITEMS);
            phase++;
        end

        no_idle = 1'b0;
        settle();
        if (mismatch_count == 0 && pending_reads == 0) begin
            $display("binary_matrix_vector_subset_table_core verification clean");
        end else begin
            $display("binary_matrix_vector_subset_table_core verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bmvst_pkg.sv
rtl/bmvst_ctrl.sv
rtl/bmvst_dp.sv
rtl/binary_matrix_vector_subset_table_core.sv
tb/sv/bmvst_result_checker.sv
tb/sv/tb_binary_matrix_vector_subset_table_core.sv
